// ===== rtl/core/spfa_pkg.sv =====
// Shared types and constants for the slice pool first-fit allocator.
// Used by every module of the block; depends on nothing else.
package spfa_pkg;

  localparam int MAX_SLICES_DEF = 64;

  localparam int KIND_W   = 2;
  localparam int BYTES_W  = 19;
  localparam int OFFSET_W = 18;
  localparam int STATUS_W = 3;
  localparam int RUN_W    = 7;
  localparam int SLICE_W  = 13;
  localparam int COUNT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETURN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd5;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_BYTES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICES_IN_USE = 1'd1;

  localparam logic [SLICE_W-1:0] SLICE_BYTES_RST = 13'd64;
  localparam logic [SLICE_W-1:0] SLICE_BYTES_MAX = 13'd4096;
  localparam logic [COUNT_W-1:0] SLICES_RST      = 7'd64;

  localparam int DIV_STEPS = BYTES_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic               start;
    logic [BYTES_W-1:0] num;
    logic [SLICE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [BYTES_W-1:0] quot;
    logic [SLICE_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
    logic [RUN_W-1:0]    run;
  } seq_res_t;

endpackage

// ===== rtl/core/spfa_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on spfa_pkg for widths and the request and response structs.
module spfa_div (
  input  logic                clk,
  input  logic                rst_n,
  input  spfa_pkg::div_req_t  req,
  output spfa_pkg::div_rsp_t  rsp
);

  localparam int BW = spfa_pkg::BYTES_W;
  localparam int SW = spfa_pkg::SLICE_W;
  localparam int CW = spfa_pkg::DIV_CNT_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] num_r, num_nxt;
  logic [BW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] den_r, den_nxt;
  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic          ge;

  always_comb begin
    trial    = {rem_r, num_r[BW-1]};
    ge       = trial >= {1'b0, den_r};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = req.num;
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[SW-1:0] : trial[SW-1:0];
      quo_nxt = {quo_r[BW-2:0], ge};
      num_nxt = num_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(spfa_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/core/spfa_seq.sv =====
// Sequencer that owns the free and start bitmaps and walks them one slice per cycle.
// Depends on spfa_pkg and drives the shared divider spfa_div through its structs.
module spfa_seq #(
  parameter int MAX_SLICES = spfa_pkg::MAX_SLICES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [spfa_pkg::KIND_W-1:0]          in_kind,
  input  logic [spfa_pkg::BYTES_W-1:0]         in_req_bytes,
  input  logic [spfa_pkg::OFFSET_W-1:0]        in_ret_offset,
  input  logic [spfa_pkg::SLICE_W-1:0]         eff_bytes,
  input  logic [$clog2(MAX_SLICES+1)-1:0]      eff_cnt,
  output spfa_pkg::div_req_t                   div_req,
  input  spfa_pkg::div_rsp_t                   div_rsp,
  output spfa_pkg::seq_res_t                   res,
  input  logic                                 res_ready
);

  localparam int IDX_W = $clog2(MAX_SLICES);
  localparam int CNT_W = $clog2(MAX_SLICES + 1);
  localparam int BW    = spfa_pkg::BYTES_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_MARK = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_FREE = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]                      state_r, state_nxt;
  logic [spfa_pkg::KIND_W-1:0]     kind_r, kind_nxt;
  logic [spfa_pkg::OFFSET_W-1:0]   ret_off_r, ret_off_nxt;
  logic [MAX_SLICES-1:0]           free_r, free_nxt;
  logic [MAX_SLICES-1:0]           start_r, start_nxt;
  logic [CNT_W-1:0]                need_r, need_nxt;
  logic [CNT_W-1:0]                ptr_r, ptr_nxt;
  logic [CNT_W-1:0]                run_r, run_nxt;
  logic [CNT_W-1:0]                first_r, first_nxt;
  logic [CNT_W-1:0]                last_r, last_nxt;
  logic [CNT_W-1:0]                idx_r, idx_nxt;
  logic [spfa_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [spfa_pkg::OFFSET_W-1:0]   off_r, off_nxt;
  logic [spfa_pkg::RUN_W-1:0]      runout_r, runout_nxt;
  logic [IDX_W-1:0]                ptr_idx;
  logic                            free_bit;
  logic                            start_bit;
  logic [BW:0]                     need_full;
  logic [CNT_W-1:0]                run_inc;
  logic [CNT_W+spfa_pkg::SLICE_W-1:0] prod;

  always_comb begin
    ptr_idx    = ptr_r[IDX_W-1:0];
    free_bit   = free_r[ptr_idx];
    start_bit  = start_r[ptr_idx];
    need_full  = {1'b0, div_rsp.quot} + (BW+1)'(div_rsp.rem != '0);
    run_inc    = free_bit ? run_r + 1'b1 : '0;
    prod       = first_r * eff_bytes;
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    ret_off_nxt = ret_off_r;
    free_nxt   = free_r;
    start_nxt  = start_r;
    need_nxt   = need_r;
    ptr_nxt    = ptr_r;
    run_nxt    = run_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    off_nxt    = off_r;
    runout_nxt = runout_r;
    div_req.start = 1'b0;
    div_req.num   = in_kind == spfa_pkg::KIND_ALLOC ? in_req_bytes : BW'(in_ret_offset);
    div_req.den   = eff_bytes;
    in_ready   = state_r == S_IDLE;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          ret_off_nxt = in_ret_offset;
          off_nxt     = '0;
          runout_nxt  = '0;
          case (in_kind)
            spfa_pkg::KIND_ALLOC: begin
              if (in_req_bytes == '0) begin
                status_nxt = spfa_pkg::ST_ZERO;
                state_nxt  = S_FIN;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
            spfa_pkg::KIND_RETURN: begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
            spfa_pkg::KIND_CLEAR: begin
              free_nxt   = '1;
              start_nxt  = '0;
              status_nxt = spfa_pkg::ST_CLEARED;
              state_nxt  = S_FIN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          ptr_nxt = '0;
          run_nxt = '0;
          if (kind_r == spfa_pkg::KIND_ALLOC) begin
            if (need_full > (BW+1)'(eff_cnt)) begin
              status_nxt = spfa_pkg::ST_NOSPACE;
              state_nxt  = S_FIN;
            end else begin
              need_nxt  = CNT_W'(need_full);
              state_nxt = S_SCAN;
            end
          end else if (div_rsp.rem != '0 || div_rsp.quot >= BW'(eff_cnt)) begin
            status_nxt = spfa_pkg::ST_NOTFOUND;
            state_nxt  = S_FIN;
          end else begin
            ptr_nxt   = CNT_W'(div_rsp.quot);
            state_nxt = S_CHK;
          end
        end
      end
      S_SCAN: begin
        run_nxt = run_inc;
        if (run_inc == need_r) begin
          first_nxt = ptr_r + 1'b1 - need_r;
          last_nxt  = ptr_r;
          ptr_nxt   = ptr_r + 1'b1 - need_r;
          state_nxt = S_FILL;
        end else if (ptr_r == eff_cnt - 1'b1) begin
          status_nxt = spfa_pkg::ST_NOSPACE;
          state_nxt  = S_FIN;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_FILL: begin
        free_nxt[ptr_idx] = 1'b0;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == last_r) begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        start_nxt[first_r[IDX_W-1:0]] = 1'b1;
        status_nxt = spfa_pkg::ST_ALLOC;
        off_nxt    = spfa_pkg::OFFSET_W'(prod);
        runout_nxt = spfa_pkg::RUN_W'(need_r);
        state_nxt  = S_FIN;
      end
      S_CHK: begin
        if (!start_bit) begin
          status_nxt = spfa_pkg::ST_NOTFOUND;
          state_nxt  = S_FIN;
        end else begin
          start_nxt[ptr_idx] = 1'b0;
          idx_nxt   = ptr_r;
          run_nxt   = '0;
          state_nxt = S_FREE;
        end
      end
      S_FREE: begin
        if (ptr_r >= eff_cnt || free_bit || (ptr_r != idx_r && start_bit)) begin
          status_nxt = spfa_pkg::ST_FREED;
          off_nxt    = ret_off_r;
          runout_nxt = spfa_pkg::RUN_W'(run_r);
          state_nxt  = S_FIN;
        end else begin
          free_nxt[ptr_idx] = 1'b1;
          run_nxt = run_r + 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_r  <= '1;
      start_r <= '0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      start_r <= start_nxt;
    end
    kind_r    <= kind_nxt;
    ret_off_r <= ret_off_nxt;
    need_r    <= need_nxt;
    ptr_r     <= ptr_nxt;
    run_r     <= run_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    idx_r     <= idx_nxt;
    status_r  <= status_nxt;
    off_r     <= off_nxt;
    runout_r  <= runout_nxt;
  end

  assign res.valid  = state_r == S_FIN;
  assign res.status = status_r;
  assign res.offset = off_r;
  assign res.run    = runout_r;

  a_start_not_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r & free_r) == '0)
    else $error("A slice marked as an allocation start is also marked free.");

  a_fill_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> free_bit)
    else $error("The fill pass reached a slice that was not free.");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("The divider finished while the sequencer was not waiting for it.");

  a_freed_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.status == spfa_pkg::ST_FREED |-> res.run != '0)
    else $error("A successful return freed no slices.");

endmodule

// ===== rtl/core/slice_pool_first_fit_allocator.sv =====
// Slice pool allocator, first fit over a free bitmap, one item in flight. Every item
// accepted on the in_ channel yields one result on out_ except kind 3, which is dropped.
// A granted request runs the divider, scans the bitmap up to the last slice of the run
// and then fills the run; a request with no fitting run scans the whole pool. A request
// larger than the pool or a misaligned or out-of-range return ends after the divider,
// and a return that does not hit an allocation start ends after the start check; a
// return walks the slices that it frees. A clear or a zero-byte request skips the
// divider. The next item is accepted at the earliest in the cycle after its result is
// loaded, and a result that waits on out_ready holds the block. Every nonzero byte count
// and byte offset is turned into slices by the shared 19-step restoring divider, and the
// sequencer reads the bitmaps one slice per cycle. There is no clearing pass after
// reset, and configuration writes are accepted at any time but must be made only while
// the block is idle.
module slice_pool_first_fit_allocator #(
  parameter int MAX_SLICES = spfa_pkg::MAX_SLICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [spfa_pkg::KIND_W-1:0]        in_kind,
  input  logic [spfa_pkg::BYTES_W-1:0]       in_req_bytes,
  input  logic [spfa_pkg::OFFSET_W-1:0]      in_ret_offset,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [spfa_pkg::STATUS_W-1:0]      out_status,
  output logic [spfa_pkg::OFFSET_W-1:0]      out_alloc_offset,
  output logic [spfa_pkg::RUN_W-1:0]         out_run_slices,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spfa_pkg::SLICE_W-1:0]       cfg_data
);

  localparam int CNT_W = $clog2(MAX_SLICES + 1);
  localparam int EXT_W = (CNT_W > spfa_pkg::COUNT_W) ? CNT_W : spfa_pkg::COUNT_W;

  logic [spfa_pkg::SLICE_W-1:0]   slice_bytes_r, slice_bytes_nxt;
  logic [spfa_pkg::COUNT_W-1:0]   slices_r, slices_nxt;
  logic [spfa_pkg::SLICE_W-1:0]   eff_bytes;
  logic [CNT_W-1:0]               eff_cnt;
  logic [EXT_W-1:0]               slices_ext;
  logic                           out_valid_r, out_valid_nxt;
  logic [spfa_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [spfa_pkg::OFFSET_W-1:0]  offset_r, offset_nxt;
  logic [spfa_pkg::RUN_W-1:0]     run_r, run_nxt;
  logic                           res_ready;
  spfa_pkg::div_req_t             div_req;
  spfa_pkg::div_rsp_t             div_rsp;
  spfa_pkg::seq_res_t             res;

  assign cfg_ready = 1'b1;

  always_comb begin
    slice_bytes_nxt = slice_bytes_r;
    slices_nxt      = slices_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        spfa_pkg::CFG_SLICE_BYTES:   slice_bytes_nxt = cfg_data;
        spfa_pkg::CFG_SLICES_IN_USE: slices_nxt = cfg_data[spfa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slice_bytes_r == '0) begin
      eff_bytes = spfa_pkg::SLICE_W'(1);
    end else if (slice_bytes_r > spfa_pkg::SLICE_BYTES_MAX) begin
      eff_bytes = spfa_pkg::SLICE_BYTES_MAX;
    end else begin
      eff_bytes = slice_bytes_r;
    end
    slices_ext = EXT_W'(slices_r);
    if (slices_r == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (slices_ext > EXT_W'(MAX_SLICES)) begin
      eff_cnt = CNT_W'(MAX_SLICES);
    end else begin
      eff_cnt = CNT_W'(slices_ext);
    end
  end

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    offset_nxt    = offset_r;
    run_nxt       = run_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
      status_nxt    = res.status;
      offset_nxt    = res.offset;
      run_nxt       = res.run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_bytes_r <= spfa_pkg::SLICE_BYTES_RST;
      slices_r      <= spfa_pkg::SLICES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      slice_bytes_r <= slice_bytes_nxt;
      slices_r      <= slices_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    status_r <= status_nxt;
    offset_r <= offset_nxt;
    run_r    <= run_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_alloc_offset = offset_r;
  assign out_run_slices   = run_r;

  spfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  spfa_seq #(
    .MAX_SLICES (MAX_SLICES)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_req_bytes  (in_req_bytes),
    .in_ret_offset (in_ret_offset),
    .eff_bytes     (eff_bytes),
    .eff_cnt       (eff_cnt),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .res           (res),
    .res_ready     (res_ready)
  );

endmodule
